// ===== rtl/lfe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfe_pkg: shared constants for the linear fade envelope
// Register widths, register indexes and default parameter values.
// ----------------------------------------------------------------------------
package lfe_pkg;

	localparam int CFG_W       = 32;
	localparam int CC_W        = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CHAN_CMP_W  = 8;

	localparam int DEF_MAX_CHANNELS = 8;
	localparam int DEF_SAMPLE_BITS  = 24;
	localparam int DEF_FRAME_BITS   = 32;

	localparam logic [CFG_IDX_W-1:0] REG_FADE_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_FRAMES   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd3;

	localparam logic MODE_FADE_IN  = 1'b0;
	localparam logic MODE_FADE_OUT = 1'b1;

	typedef struct packed {
		logic start;
		logic done;
	} lfe_div_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/lfe_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfe_div: restoring unsigned divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module lfe_div
	import lfe_pkg::*;
#(
	parameter int DW = 56,
	parameter int VW = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire lfe_div_ctl_t  ctl_in,
	output lfe_div_ctl_t       ctl_out,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic [DW-1:0]      quotient
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    dvs_q;
	logic [DW-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [VW:0]      shifted;
	logic [VW:0]      diff;
	logic             take;

	assign shifted = {rem_q, quo_q[DW-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign take    = (shifted >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (ctl_in.start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= take ? diff[VW-1:0] : shifted[VW-1:0];
			quo_q <= {quo_q[DW-2:0], take};
		end
	end

	assign quotient      = quo_q;
	assign ctl_out.start = 1'b0;
	assign ctl_out.done  = done_q;

endmodule
`default_nettype wire

// ===== rtl/linear_fade_envelope_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// linear_fade_envelope_top: linear fade-in / fade-out gain
// Tracks frame and channel position of interleaved samples and scales
// samples inside the fade region by a linear gain, truncated toward zero.
// ----------------------------------------------------------------------------
// One request at a time. A sample outside the fade region passes through
// the evaluate and done states to the output register; a sample inside it
// also passes the multiply and divide states, where the restoring divider
// produces one quotient bit per cycle. The input is ready again once the
// result has moved into the output register, so a result may wait there
// while the next request is already in work.
module linear_fade_envelope_top
	import lfe_pkg::*;
#(
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
	parameter int FRAME_BITS   = DEF_FRAME_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
	input  wire logic                   restart,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic                        in_fade,
	output logic                        end_of_file
);

	localparam int CMP_W  = (FRAME_BITS > CFG_W) ? FRAME_BITS : CFG_W;
	localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int PROD_W = SAMPLE_BITS + CFG_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EVAL = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]             state_q;
	logic                   mode_q;
	logic [CFG_W-1:0]       fade_len_q;
	logic [CFG_W-1:0]       total_q;
	logic [CC_W-1:0]        chcnt_q;
	logic [FRAME_BITS-1:0]  frame_q;
	logic [CH_W-1:0]        chan_q;

	logic [SAMPLE_BITS-1:0] raw_q;
	logic                   restart_q;
	logic                   fade_q;
	logic                   eof_q;
	logic                   neg_q;
	logic [SAMPLE_BITS-1:0] mag_q;
	logic [CFG_W-1:0]       num_q;
	logic [CFG_W-1:0]       fdiv_q;

	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] sample_out_q;
	logic                   in_fade_q;
	logic                   eof_out_q;

	logic [FRAME_BITS-1:0]  pos_i;
	logic [CH_W-1:0]        pos_c;
	logic [CMP_W-1:0]       i_x;
	logic [CMP_W-1:0]       tot_x;
	logic [CMP_W-1:0]       ff_x;
	logic [CMP_W-1:0]       f_x;
	logic [CMP_W-1:0]       num_x;
	logic                   fade_c;
	logic [CHAN_CMP_W-1:0]  cc_x;
	logic [CHAN_CMP_W-1:0]  eff_ch;
	logic                   last_ch;
	logic                   eof_c;

	lfe_div_ctl_t           div_in;
	lfe_div_ctl_t           div_out;
	logic [PROD_W-1:0]      product;
	logic [PROD_W-1:0]      quo;
	logic [SAMPLE_BITS-1:0] q_lo;
	logic [SAMPLE_BITS-1:0] res_div;
	logic                   accept;
	logic                   load_out;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// position, fade region and end of file of the held sample
	always_comb begin
		pos_i   = restart_q ? '0 : frame_q;
		pos_c   = restart_q ? '0 : chan_q;
		i_x     = CMP_W'(pos_i);
		tot_x   = CMP_W'(total_q);
		ff_x    = CMP_W'(fade_len_q);
		f_x     = (ff_x > tot_x) ? tot_x : ff_x;
		fade_c  = 1'b0;
		num_x   = '0;
		if (f_x != '0) begin
			if (mode_q == MODE_FADE_IN) begin
				if (i_x < f_x) begin
					fade_c = 1'b1;
					num_x  = i_x;
				end
			end else begin
				if ((i_x >= tot_x - f_x) && (i_x < tot_x)) begin
					fade_c = 1'b1;
					num_x  = tot_x - i_x;
				end
			end
		end
		cc_x = CHAN_CMP_W'(chcnt_q);
		if (cc_x == '0) begin
			eff_ch = CHAN_CMP_W'(1);
		end else if (cc_x > CHAN_CMP_W'(MAX_CHANNELS)) begin
			eff_ch = CHAN_CMP_W'(MAX_CHANNELS);
		end else begin
			eff_ch = cc_x;
		end
		last_ch = ((CHAN_CMP_W'(pos_c) + CHAN_CMP_W'(1)) >= eff_ch);
		eof_c   = last_ch && (tot_x != '0) && (i_x == tot_x - CMP_W'(1));
	end

	assign product      = PROD_W'(mag_q) * PROD_W'(num_q);
	assign div_in.start = (state_q == ST_MUL);
	assign div_in.done  = 1'b0;
	assign q_lo         = quo[SAMPLE_BITS-1:0];
	assign res_div      = neg_q ? (~q_lo + SAMPLE_BITS'(1)) : q_lo;

	lfe_div #(
		.DW (PROD_W),
		.VW (CFG_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (div_in),
		.ctl_out  (div_out),
		.dividend (product),
		.divisor  (fdiv_q),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_FADE_IN;
			fade_len_q  <= '0;
			total_q     <= '0;
			chcnt_q     <= CC_W'(1);
			frame_q     <= '0;
			chan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FADE_MODE:     mode_q     <= cfg_data[0];
					REG_FADE_FRAMES:   fade_len_q <= cfg_data;
					REG_TOTAL_FRAMES:  total_q    <= cfg_data;
					REG_CHANNEL_COUNT: chcnt_q    <= cfg_data[CC_W-1:0];
					default:           mode_q     <= mode_q;
				endcase
			end
			out_valid_q <= load_out || (out_valid_q && !out_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					// advance position
					if (eof_c) begin
						frame_q <= '0;
						chan_q  <= '0;
					end else if (last_ch) begin
						frame_q <= pos_i + FRAME_BITS'(1);
						chan_q  <= '0;
					end else begin
						frame_q <= pos_i;
						chan_q  <= pos_c + CH_W'(1);
					end
					state_q <= fade_c ? ST_MUL : ST_DONE;
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_out.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_q     <= sample_in;
			restart_q <= restart;
		end
		if (state_q == ST_EVAL) begin
			fade_q <= fade_c;
			eof_q  <= eof_c;
			neg_q  <= raw_q[SAMPLE_BITS-1];
			mag_q  <= raw_q[SAMPLE_BITS-1] ? (~raw_q + SAMPLE_BITS'(1)) : raw_q;
			num_q  <= num_x[CFG_W-1:0];
			fdiv_q <= f_x[CFG_W-1:0];
		end
		if (load_out) begin
			sample_out_q <= fade_q ? res_div : raw_q;
			in_fade_q    <= fade_q;
			eof_out_q    <= eof_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign sample_out  = sample_out_q;
	assign in_fade     = in_fade_q;
	assign end_of_file = eof_out_q;

	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EVAL))
		else $error("accepted request did not enter evaluation");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_out.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (out_valid_q && (state_q == ST_IDLE)))
		else $error("loaded result not presented");

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: linear fade envelope
// Drives interleaved samples through a valid/ready handshake under random
// gaps and output stalls. A scoreboard tracks frame and channel position and
// register settings, predicts every faded sample and compares each result.
// ----------------------------------------------------------------------------
module testbench;
	import lfe_pkg::*;

	localparam int SW           = DEF_SAMPLE_BITS;
	localparam int RANDOM_ITEMS = 1300;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 64;
	localparam int GAP_MAX      = 18;

	typedef struct packed {
		logic [SW-1:0] sample;
		logic          fade;
		logic          eof;
	} fade_result_t;

	class fade_gain_checker;
		logic          mode;
		logic [31:0]   fade_len;
		logic [31:0]   total_len;
		logic [CC_W-1:0] chan_cfg;
		logic [31:0]   frame_pos;
		int unsigned   chan_pos;
		fade_result_t  expected_q[$];
		int            errors;
		int            checked;

		function new();
			mode      = MODE_FADE_IN;
			fade_len  = '0;
			total_len = '0;
			chan_cfg  = 1;
			frame_pos = '0;
			chan_pos  = 0;
			errors    = 0;
			checked   = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_FADE_MODE:     mode = val[0];
				REG_FADE_FRAMES:   fade_len = val;
				REG_TOTAL_FRAMES:  total_len = val;
				REG_CHANNEL_COUNT: chan_cfg = val[CC_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_request(logic [SW-1:0] smp, logic rs);
			logic [63:0]  mag, num, f, q, pos, tot;
			logic         neg, fade, last_ch, eof;
			int unsigned  chans;
			fade_result_t r;
			chans = (chan_cfg == 0) ? 1 : ((chan_cfg > 8) ? 8 : chan_cfg);
			if (rs) begin
				frame_pos = '0;
				chan_pos  = 0;
			end
			neg  = smp[SW-1];
			mag  = neg ? ((64'd1 << SW) - 64'(smp)) : 64'(smp);
			pos  = 64'(frame_pos);
			tot  = 64'(total_len);
			f    = 64'(fade_len);
			if (f > tot)
				f = tot;
			fade = 1'b0;
			num  = '0;
			if (f != 0) begin
				if (mode == MODE_FADE_IN) begin
					if (pos < f) begin
						fade = 1'b1;
						num  = pos;
					end
				end else if (pos >= tot - f && pos < tot) begin
					fade = 1'b1;
					num  = tot - pos;
				end
			end
			if (fade) begin
				q = (mag * num) / f;
				if (neg)
					q = 64'd0 - q;
				r.sample = q[SW-1:0];
			end else begin
				r.sample = smp;
			end
			last_ch = (chan_pos + 1) >= chans;
			eof     = last_ch && tot != 0 && pos == tot - 1;
			r.fade  = fade;
			r.eof   = eof;
			expected_q.push_back(r);
			if (eof) begin
				frame_pos = '0;
				chan_pos  = 0;
			end else if (last_ch) begin
				chan_pos  = 0;
				frame_pos = frame_pos + 1;
			end else begin
				chan_pos = chan_pos + 1;
			end
		endfunction

		function void check_result(logic [SW-1:0] smp, logic fade, logic eof);
			fade_result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: sample_out=%h in_fade=%b end_of_file=%b",
						smp, fade, eof);
				return;
			end
			want = expected_q.pop_front();
			if (smp !== want.sample || fade !== want.fade || eof !== want.eof) begin
				errors++;
				if (errors <= 10)
					$display({"result %0d mismatch: expected sample_out=%h in_fade=%b ",
						"end_of_file=%b, got sample_out=%h in_fade=%b end_of_file=%b"},
						checked, want.sample, want.fade, want.eof, smp, fade, eof);
			end
			checked++;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic signed [SW-1:0]  sample_in;
	logic                  restart;
	logic                  out_valid;
	logic                  out_ready;
	logic signed [SW-1:0]  sample_out;
	logic                  in_fade;
	logic                  end_of_file;

	int unsigned send_gap_max = 3;
	int unsigned recv_gap_max = 3;
	int unsigned random_sent  = 0;
	int unsigned cycle_count  = 0;

	fade_gain_checker gain_model = new();

	linear_fade_envelope_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_in   (sample_in),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sample_out  (sample_out),
		.in_fade     (in_fade),
		.end_of_file (end_of_file)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && in_valid === 1'b1 && in_ready === 1'b1)
			gain_model.note_request(sample_in, restart);
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
			gain_model.check_result(sample_out, in_fade, end_of_file);
	end

	// stall the result side per request
	initial begin
		int unsigned stall;
		out_ready = 1'b1;
		forever begin
			stall = $urandom_range(0, recv_gap_max);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
				out_ready <= 1'b1;
			end
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		gain_model.set_reg(idx, val);
	endtask

	task automatic set_config(input logic m, input logic [31:0] fl, input logic [31:0] tl,
			input logic [CC_W-1:0] cc);
		write_reg(REG_FADE_MODE, CFG_W'(m));
		write_reg(REG_FADE_FRAMES, fl);
		write_reg(REG_TOTAL_FRAMES, tl);
		write_reg(REG_CHANNEL_COUNT, CFG_W'(cc));
	endtask

	task automatic send_item(input logic [SW-1:0] smp, input logic rs);
		int unsigned gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= smp;
		restart   <= rs;
		do @(posedge clk); while (in_ready !== 1'b1);
	endtask

	// hold the sender until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (gain_model.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [SW-1:0] corner_sample(int unsigned k);
		case (k % 5)
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'h000000;
			3: return 24'hFFFFFF;
			default: return 24'h000001;
		endcase
	endfunction

	task automatic send_corners(input int unsigned n, input logic first_restart);
		for (int unsigned k = 0; k < n; k++)
			send_item(corner_sample(k), first_restart && k == 0);
	endtask

	task automatic run_random_file();
		logic            m;
		logic [31:0]     fl, tl;
		logic [CC_W-1:0] cc;
		int unsigned     chans_eff, n;
		logic            fresh, rs;
		logic [SW-1:0]   smp;
		m = ($urandom_range(0, 1) != 0) ? MODE_FADE_OUT : MODE_FADE_IN;
		case ($urandom_range(0, 9))
			0: tl = '0;
			1: tl = $urandom;
			2: tl = 32'hFFFF_FFFF;
			3: tl = $urandom_range(25, 60);
			default: tl = $urandom_range(1, 24);
		endcase
		case ($urandom_range(0, 9))
			0: fl = '0;
			1: fl = 32'hFFFF_FFFF;
			2: fl = $urandom;
			3: fl = tl;
			default: fl = $urandom_range(1, (tl < 64) ? tl + 3 : 67);
		endcase
		if ($urandom_range(0, 3) == 0)
			cc = CC_W'($urandom_range(0, 15));
		else
			cc = CC_W'($urandom_range(1, 4));
		chans_eff = (cc == 0) ? 1 : ((cc > 8) ? 8 : cc);
		if (tl != 0 && tl <= 60)
			n = tl * chans_eff + $urandom_range(0, chans_eff);
		else
			n = $urandom_range(5, 40);
		fresh = ($urandom_range(0, 3) != 0);
		send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
		recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
		set_config(m, fl, tl, cc);
		for (int unsigned k = 0; k < n; k++) begin
			case ($urandom_range(0, 15))
				0, 1, 2, 3: smp = corner_sample($urandom_range(0, 4));
				default: smp = SW'($urandom);
			endcase
			rs = (k == 0 && fresh) || ($urandom_range(0, 49) == 0);
			send_item(smp, rs);
		end
		random_sent += n;
		drain();
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		sample_in = '0;
		restart   = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: no fade, no end of file
		send_corners(3, 1'b1);
		drain();
		// fade longer than file, channel count zero, wrap after end of file
		set_config(MODE_FADE_IN, 32'd3, 32'd2, 4'd0);
		send_corners(3, 1'b1);
		drain();
		set_config(MODE_FADE_OUT, 32'd2, 32'd3, 4'd2);
		send_corners(6, 1'b1);
		drain();
		// channel count saturates
		set_config(MODE_FADE_OUT, 32'd2, 32'd1, 4'd15);
		send_corners(9, 1'b1);
		drain();
		// lower count and total mid-file: frame ends early, frames past total
		set_config(MODE_FADE_IN, 32'd4, 32'd4, 4'd3);
		send_corners(4, 1'b1);
		drain();
		set_config(MODE_FADE_IN, 32'd4, 32'd1, 4'd1);
		send_corners(2, 1'b0);
		drain();

		while (random_sent < RANDOM_ITEMS)
			run_random_file();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (gain_model.errors == 0 && gain_model.pending() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule

// ===== linear_fade_envelope_top.f =====
rtl/lfe_pkg.sv
rtl/lfe_div.sv
rtl/linear_fade_envelope_top.sv
sim/testbench.sv
